// ===== src/qla_pkg.sv =====
// Shared constants, types and helper functions of the tabular Q-learning agent.
package qla_pkg;

  // Table geometry.
  localparam int QUANT_LEVELS = 100;
  localparam int ACTION_STEPS = 10;
  localparam int QVALUE_WIDTH = 32;

  localparam int ROW_LEN  = ACTION_STEPS + 1;
  localparam int NUM_ROWS = (QUANT_LEVELS + 1) * (QUANT_LEVELS + 1);
  localparam int Q_DEPTH  = NUM_ROWS * ROW_LEN;

  localparam int LEVEL_W = $clog2(QUANT_LEVELS + 1);
  localparam int ACT_W   = $clog2(ROW_LEN);
  localparam int ROW_W   = $clog2(NUM_ROWS);
  localparam int ADDR_W  = $clog2(Q_DEPTH);

  // Fixed field widths.
  localparam int FRAC_W     = 17;
  localparam int FRAC_SHIFT = 16;
  localparam int PROB_W     = 16;
  localparam int REW_W      = 32;
  localparam int IDX_W      = 4;
  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ONE_Q16    = 65536;

  // Update datapath widths.
  localparam int QW    = QVALUE_WIDTH;
  localparam int TGT_W = ((QW > REW_W) ? QW : REW_W) + 2;
  localparam int DIF_W = TGT_W + 1;
  localparam int SUM_W = DIF_W + 1;
  localparam int GP_W  = QW + PROB_W + 1;
  localparam int AP_W  = DIF_W + PROB_W + 1;

  // Operation codes.
  localparam logic [1:0] OP_SELECT = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_DECAY  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS_START     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS_DECAY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS_FLOOR     = 3'd4;

  // Register values after reset.
  localparam logic [PROB_W-1:0] LR_RESET    = 16'd6554;
  localparam logic [PROB_W-1:0] GAMMA_RESET = 16'd58982;
  localparam logic [PROB_W-1:0] EPS_RESET   = 16'd6554;
  localparam logic [PROB_W-1:0] DECAY_RESET = 16'd65208;
  localparam logic [PROB_W-1:0] FLOOR_RESET = 16'd655;

  typedef logic [FRAC_W-1:0]     frac_t;
  typedef logic [PROB_W-1:0]     prob_t;
  typedef logic signed [QW-1:0]  qval_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [ACT_W-1:0]      act_t;
  typedef logic [LEVEL_W-1:0]    level_t;
  typedef logic [ROW_W-1:0]      row_t;

  // One access cycle of the Q table.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    qval_t wdata;
    logic  re;
    addr_t raddr;
  } qmem_req_t;

  // Tells the row scanner that read data is valid and which action it belongs to.
  typedef struct packed {
    logic fold;
    act_t idx;
  } rowmax_ctl_t;

  typedef logic [ROW_LEN-1:0][FRAC_W-1:0] inten_tbl_t;

  function automatic frac_t clamp_one(frac_t f);
    return (f > frac_t'(ONE_Q16)) ? frac_t'(ONE_Q16) : f;
  endfunction

  function automatic level_t level_of(frac_t f);
    logic [FRAC_W+LEVEL_W-1:0] p;
    p = (FRAC_W + LEVEL_W)'(clamp_one(f)) * (FRAC_W + LEVEL_W)'(QUANT_LEVELS);
    return p[FRAC_SHIFT +: LEVEL_W];
  endfunction

  function automatic act_t index_of(frac_t f);
    logic [FRAC_W+ACT_W-1:0] p;
    p = (FRAC_W + ACT_W)'(clamp_one(f)) * (FRAC_W + ACT_W)'(ACTION_STEPS);
    return p[FRAC_SHIFT +: ACT_W];
  endfunction

  // Smallest intensity whose scaled floor gives the action index back.
  function automatic inten_tbl_t build_inten_tbl();
    inten_tbl_t t;
    for (int i = 0; i < ROW_LEN; i++) begin
      t[i] = FRAC_W'((i * ONE_Q16 + ACTION_STEPS - 1) / ACTION_STEPS);
    end
    return t;
  endfunction

  localparam inten_tbl_t GREEDY_INTEN = build_inten_tbl();

  // Low 32 bits of a Q value, sign extended first when the table is narrower.
  function automatic logic [VAL_W-1:0] q_to_out(qval_t q);
    logic signed [QW+VAL_W-1:0] ext;
    ext = (QW + VAL_W)'(q);
    return ext[VAL_W-1:0];
  endfunction

endpackage

// ===== src/qla_qtable.sv =====
// Q table storage: one write port and one registered read port.
module qla_qtable (
  input  logic               clk,
  input  qla_pkg::qmem_req_t req,
  output qla_pkg::qval_t     rdata
);

  qla_pkg::qval_t mem [qla_pkg::Q_DEPTH];
  qla_pkg::qval_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/qla_rowmax.sv =====
// Running maximum over one table row, keeping the lowest action index on ties.
module qla_rowmax (
  input  logic                 clk,
  input  qla_pkg::qval_t       rd_data,
  input  qla_pkg::rowmax_ctl_t ctl,
  output qla_pkg::qval_t       best,
  output qla_pkg::act_t        pick
);

  qla_pkg::qval_t best_r;
  qla_pkg::act_t  pick_r;

  // The first entry of a row always loads; later ones only when strictly greater.
  always_ff @(posedge clk) begin
    if (ctl.fold && ((ctl.idx == '0) || (rd_data > best_r))) begin
      best_r <= rd_data;
      pick_r <= ctl.idx;
    end
  end

  assign best = best_r;
  assign pick = pick_r;

endmodule

// ===== src/qla_update.sv =====
// Five-stage pipeline for the Q update: target, difference, step and saturation.
module qla_update (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                launch,
  input  qla_pkg::qval_t                      cur,
  input  qla_pkg::qval_t                      maxnext,
  input  logic signed [qla_pkg::REW_W-1:0]    reward,
  input  qla_pkg::prob_t                      alpha,
  input  qla_pkg::prob_t                      gamma,
  output qla_pkg::qval_t                      nq,
  output logic                                done
);

  logic [4:0] v_r;

  qla_pkg::qval_t                      cur1_r, cur2_r, cur3_r, cur4_r, nq_r;
  logic signed [qla_pkg::REW_W-1:0]    rew1_r;
  logic signed [qla_pkg::GP_W-1:0]     gprod1_r;
  logic signed [qla_pkg::TGT_W-1:0]    tgt2_r;
  logic signed [qla_pkg::DIF_W-1:0]    diff3_r;
  logic signed [qla_pkg::AP_W-1:0]     aprod4_r;
  logic signed [qla_pkg::SUM_W-1:0]    sum_c;
  qla_pkg::qval_t                      sat_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], launch};
    end
  end

  // Products with a Q0.16 factor are exact; the arithmetic shift floors them.
  always_ff @(posedge clk) begin
    cur1_r   <= cur;
    rew1_r   <= reward;
    gprod1_r <= $signed({1'b0, gamma}) * maxnext;

    cur2_r   <= cur1_r;
    tgt2_r   <= qla_pkg::TGT_W'(rew1_r) + qla_pkg::TGT_W'(gprod1_r >>> qla_pkg::FRAC_SHIFT);

    cur3_r   <= cur2_r;
    diff3_r  <= qla_pkg::DIF_W'(tgt2_r) - qla_pkg::DIF_W'(cur2_r);

    cur4_r   <= cur3_r;
    aprod4_r <= $signed({1'b0, alpha}) * diff3_r;

    nq_r     <= sat_c;
  end

  always_comb begin
    sum_c = qla_pkg::SUM_W'(cur4_r) + qla_pkg::SUM_W'(aprod4_r >>> qla_pkg::FRAC_SHIFT);
    if ((&sum_c[qla_pkg::SUM_W-1:qla_pkg::QW-1]) || !(|sum_c[qla_pkg::SUM_W-1:qla_pkg::QW-1])) begin
      sat_c = sum_c[qla_pkg::QW-1:0];
    end else if (sum_c[qla_pkg::SUM_W-1]) begin
      sat_c = {1'b1, {(qla_pkg::QW-1){1'b0}}};
    end else begin
      sat_c = {1'b0, {(qla_pkg::QW-1){1'b1}}};
    end
  end

  assign nq   = nq_r;
  assign done = v_r[4];

endmodule

// ===== src/tabular_q_learning_agent.sv =====
// Top level of the tabular Q-learning agent with epsilon-greedy action choice.
//
// Usage: an item is taken on a rising edge where start is high and busy is
// low. Its op selects an action, updates one table entry or decays epsilon.
// Exactly one result follows each item: it stands on the out_ ports for one
// cycle with out_valid high. The receiver cannot hold results back, so the
// block never waits on the output side.
//
// Work per item: an exploring select, a decay and the unused op go straight
// to the result; a greedy select scans the current row, and an update scans
// the next-state row and then runs the five-stage update pipeline. A new item
// may be started in the cycle in which the result is shown. The row scan reads
// the eleven entries of a row through the single read port of the Q table,
// one a cycle.
//
// After reset the block sweeps all 112211 entries of the Q table to zero, one
// entry a cycle; busy stays high until the sweep is done. Configuration writes
// are taken at any time, also during the sweep, and have no wait.
module tabular_q_learning_agent (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_op,
  input  logic [qla_pkg::FRAC_W-1:0]        in_infected_now,
  input  logic [qla_pkg::FRAC_W-1:0]        in_hospitalized_now,
  input  logic [qla_pkg::FRAC_W-1:0]        in_infected_next,
  input  logic [qla_pkg::FRAC_W-1:0]        in_hospitalized_next,
  input  logic [qla_pkg::FRAC_W-1:0]        in_taken_intensity,
  input  logic signed [qla_pkg::REW_W-1:0]  in_reward,
  input  logic [qla_pkg::PROB_W-1:0]        in_random_draw,
  input  logic [qla_pkg::PROB_W-1:0]        in_random_intensity,
  input  logic                              cfg_we,
  input  logic [qla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qla_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                              out_valid,
  output logic [qla_pkg::FRAC_W-1:0]        out_action_intensity,
  output logic [qla_pkg::IDX_W-1:0]         out_action_index,
  output logic                              out_explored,
  output logic signed [qla_pkg::VAL_W-1:0]  out_value_out
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LEVEL,
    S_ROW,
    S_BASE,
    S_SCAN,
    S_SCAN_END,
    S_UPD_GO,
    S_UPD_WAIT,
    S_FINISH
  } state_t;

  state_t state_r;

  // Sweep counter for the table clear after reset.
  qla_pkg::addr_t clr_r;

  // Latched item.
  logic [1:0]                        op_r;
  logic                              explore_r;
  qla_pkg::frac_t                    inf_r, hosp_r, ninf_r, nhosp_r, taken_r;
  logic signed [qla_pkg::REW_W-1:0]  reward_r;
  qla_pkg::prob_t                    rint_r;

  // Address generation.
  qla_pkg::level_t li_r, lh_r, nli_r, nlh_r;
  qla_pkg::act_t   act_r;
  qla_pkg::row_t   row_r, nrow_r;
  qla_pkg::addr_t  base_r, nbase_r, cur_addr_r;
  qla_pkg::act_t   a_r;
  logic            rd_fold_r;
  qla_pkg::act_t   rd_idx_r;

  // Configuration and epsilon.
  qla_pkg::prob_t lr_r, gamma_r, decay_r, floor_r, eps_r;

  // Result registers.
  logic                        out_valid_r;
  qla_pkg::frac_t              out_inten_r;
  logic [qla_pkg::IDX_W-1:0]   out_idx_r;
  logic                        out_expl_r;
  logic [qla_pkg::VAL_W-1:0]   out_val_r;

  qla_pkg::qmem_req_t   qmem_req;
  qla_pkg::qval_t       rd_data;
  qla_pkg::rowmax_ctl_t rm_ctl;
  qla_pkg::qval_t       best;
  qla_pkg::act_t        pick;
  qla_pkg::qval_t       nq;
  logic                 upd_done;

  logic [2*qla_pkg::PROB_W-1:0] eps_prod;
  qla_pkg::prob_t               eps_dec;
  qla_pkg::addr_t               scan_addr;

  assign busy = (state_r != S_IDLE);

  // Decayed epsilon, held no lower than the floor.
  always_comb begin
    eps_prod = (2 * qla_pkg::PROB_W)'(eps_r) * (2 * qla_pkg::PROB_W)'(decay_r);
    eps_dec  = eps_prod[qla_pkg::FRAC_SHIFT +: qla_pkg::PROB_W];
    if (eps_dec < floor_r) begin
      eps_dec = floor_r;
    end
  end

  // A select scans the current row; an update scans the next-state row.
  assign scan_addr = ((op_r == qla_pkg::OP_SELECT) ? base_r : nbase_r)
                     + qla_pkg::addr_t'(a_r);

  // Table port: the clear sweep, row reads, the current-entry read and the write back.
  always_comb begin
    qmem_req = '0;
    case (state_r)
      S_CLEAR: begin
        qmem_req.we    = 1'b1;
        qmem_req.waddr = clr_r;
      end
      S_SCAN: begin
        qmem_req.re    = 1'b1;
        qmem_req.raddr = scan_addr;
      end
      S_SCAN_END: begin
        qmem_req.re    = (op_r == qla_pkg::OP_UPDATE);
        qmem_req.raddr = cur_addr_r;
      end
      S_FINISH: begin
        qmem_req.we    = (op_r == qla_pkg::OP_UPDATE);
        qmem_req.waddr = cur_addr_r;
        qmem_req.wdata = nq;
      end
      default: begin
        qmem_req = '0;
      end
    endcase
  end

  assign rm_ctl.fold = rd_fold_r;
  assign rm_ctl.idx  = rd_idx_r;

  qla_qtable u_qtable (
    .clk   (clk),
    .req   (qmem_req),
    .rdata (rd_data)
  );

  qla_rowmax u_rowmax (
    .clk     (clk),
    .rd_data (rd_data),
    .ctl     (rm_ctl),
    .best    (best),
    .pick    (pick)
  );

  // The current entry arrives from the table in the launch cycle.
  qla_update u_update (
    .clk     (clk),
    .rst_n   (rst_n),
    .launch  (state_r == S_UPD_GO),
    .cur     (rd_data),
    .maxnext (best),
    .reward  (reward_r),
    .alpha   (lr_r),
    .gamma   (gamma_r),
    .nq      (nq),
    .done    (upd_done)
  );

  // Configuration registers; epsilon also changes on a decay item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r    <= qla_pkg::LR_RESET;
      gamma_r <= qla_pkg::GAMMA_RESET;
      decay_r <= qla_pkg::DECAY_RESET;
      floor_r <= qla_pkg::FLOOR_RESET;
      eps_r   <= qla_pkg::EPS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        qla_pkg::CFG_LEARNING_RATE: lr_r    <= cfg_wdata;
        qla_pkg::CFG_DISCOUNT:      gamma_r <= cfg_wdata;
        qla_pkg::CFG_EPS_START:     eps_r   <= cfg_wdata;
        qla_pkg::CFG_EPS_DECAY:     decay_r <= cfg_wdata;
        qla_pkg::CFG_EPS_FLOOR:     floor_r <= cfg_wdata;
        default: begin
        end
      endcase
    end else if ((state_r == S_FINISH) && (op_r == qla_pkg::OP_DECAY)) begin
      eps_r <= eps_dec;
    end
  end

  // Sequencer with the result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      rd_fold_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_fold_r   <= (state_r == S_SCAN);
      rd_idx_r    <= a_r;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == qla_pkg::addr_t'(qla_pkg::Q_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r     <= in_op;
            inf_r    <= in_infected_now;
            hosp_r   <= in_hospitalized_now;
            ninf_r   <= in_infected_next;
            nhosp_r  <= in_hospitalized_next;
            taken_r  <= in_taken_intensity;
            reward_r <= in_reward;
            rint_r   <= in_random_intensity;
            explore_r <= (in_op == qla_pkg::OP_SELECT) && (in_random_draw < eps_r);
            if ((in_op == qla_pkg::OP_SELECT) && (in_random_draw < eps_r)) begin
              state_r <= S_FINISH;
            end else if ((in_op == qla_pkg::OP_SELECT) || (in_op == qla_pkg::OP_UPDATE)) begin
              state_r <= S_LEVEL;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end
        S_LEVEL: begin
          li_r    <= qla_pkg::level_of(inf_r);
          lh_r    <= qla_pkg::level_of(hosp_r);
          nli_r   <= qla_pkg::level_of(ninf_r);
          nlh_r   <= qla_pkg::level_of(nhosp_r);
          act_r   <= qla_pkg::index_of(taken_r);
          state_r <= S_ROW;
        end
        S_ROW: begin
          row_r   <= qla_pkg::row_t'(li_r) * qla_pkg::row_t'(qla_pkg::QUANT_LEVELS + 1)
                     + qla_pkg::row_t'(lh_r);
          nrow_r  <= qla_pkg::row_t'(nli_r) * qla_pkg::row_t'(qla_pkg::QUANT_LEVELS + 1)
                     + qla_pkg::row_t'(nlh_r);
          state_r <= S_BASE;
        end
        S_BASE: begin
          base_r  <= qla_pkg::addr_t'(row_r) * qla_pkg::addr_t'(qla_pkg::ROW_LEN);
          nbase_r <= qla_pkg::addr_t'(nrow_r) * qla_pkg::addr_t'(qla_pkg::ROW_LEN);
          a_r     <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          cur_addr_r <= base_r + qla_pkg::addr_t'(act_r);
          a_r        <= a_r + 1'b1;
          if (a_r == qla_pkg::act_t'(qla_pkg::ROW_LEN - 1)) begin
            state_r <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          // The last entry of the row is folded in at this edge.
          if (op_r == qla_pkg::OP_SELECT) begin
            state_r <= S_FINISH;
          end else begin
            state_r <= S_UPD_GO;
          end
        end
        S_UPD_GO: begin
          state_r <= S_UPD_WAIT;
        end
        S_UPD_WAIT: begin
          if (upd_done) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          out_valid_r <= 1'b1;
          out_inten_r <= '0;
          out_idx_r   <= '0;
          out_expl_r  <= 1'b0;
          out_val_r   <= '0;
          case (op_r)
            qla_pkg::OP_SELECT: begin
              if (explore_r) begin
                out_inten_r <= qla_pkg::frac_t'(rint_r);
                out_idx_r   <= qla_pkg::IDX_W'(qla_pkg::index_of(qla_pkg::frac_t'(rint_r)));
                out_expl_r  <= 1'b1;
              end else begin
                out_inten_r <= qla_pkg::GREEDY_INTEN[pick];
                out_idx_r   <= qla_pkg::IDX_W'(pick);
                out_val_r   <= qla_pkg::q_to_out(best);
              end
            end
            qla_pkg::OP_UPDATE: begin
              out_idx_r <= qla_pkg::IDX_W'(act_r);
              out_val_r <= qla_pkg::q_to_out(nq);
            end
            qla_pkg::OP_DECAY: begin
              out_val_r <= qla_pkg::VAL_W'(eps_dec);
            end
            default: begin
            end
          endcase
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_action_intensity = out_inten_r;
  assign out_action_index     = out_idx_r;
  assign out_explored         = out_expl_r;
  assign out_value_out        = $signed(out_val_r);

endmodule

// ===== src/qla_checker.sv =====
// Port-level checks of the Q-learning agent, bound to its top level.
module qla_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic                              out_explored,
  input logic signed [qla_pkg::VAL_W-1:0]  out_value_out
);

  // An accepted item keeps the block busy until its result.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A result only follows work in flight, and ends it.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result without an item in flight");

  // One result per item: strobes never come back to back.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // An exploring select reports no value.
  a_explore_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_explored) |-> (out_value_out == 0))
    else $error("exploring result carries a value");

endmodule

bind tabular_q_learning_agent qla_checker u_qla_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_explored  (out_explored),
  .out_value_out (out_value_out)
);

// ===== sim/qla_checker.sv =====
// Checker for the tabular Q-learning agent: predicts every result and compares it.
module qla_scoreboard (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [1:0]                        in_op,
  input  logic [qla_pkg::FRAC_W-1:0]        in_infected_now,
  input  logic [qla_pkg::FRAC_W-1:0]        in_hospitalized_now,
  input  logic [qla_pkg::FRAC_W-1:0]        in_infected_next,
  input  logic [qla_pkg::FRAC_W-1:0]        in_hospitalized_next,
  input  logic [qla_pkg::FRAC_W-1:0]        in_taken_intensity,
  input  logic signed [qla_pkg::REW_W-1:0]  in_reward,
  input  logic [qla_pkg::PROB_W-1:0]        in_random_draw,
  input  logic [qla_pkg::PROB_W-1:0]        in_random_intensity,
  input  logic                              cfg_we,
  input  logic [qla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qla_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              out_valid,
  input  logic [qla_pkg::FRAC_W-1:0]        out_action_intensity,
  input  logic [qla_pkg::IDX_W-1:0]         out_action_index,
  input  logic                              out_explored,
  input  logic signed [qla_pkg::VAL_W-1:0]  out_value_out,
  output int                                fail_count,
  output int                                pending
);
  import qla_pkg::*;

  typedef struct {
    logic [FRAC_W-1:0] intensity;
    logic [IDX_W-1:0]  index;
    logic              explored;
    logic [VAL_W-1:0]  value;
  } agent_action_t;

  // Sparse shadow of the Q table; an entry that is absent holds zero.
  longint        q_shadow[int unsigned];
  prob_t         alpha, discount, eps_start, eps_decay, eps_floor, eps;
  agent_action_t awaited_actions[$];

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic int unsigned clip_frac(logic [FRAC_W-1:0] f);
    return (f > FRAC_W'(ONE_Q16)) ? ONE_Q16 : int'(f);
  endfunction

  function automatic int unsigned level_q(logic [FRAC_W-1:0] f);
    return (clip_frac(f) * QUANT_LEVELS) >> FRAC_SHIFT;
  endfunction

  function automatic int unsigned action_q(logic [FRAC_W-1:0] f);
    return (clip_frac(f) * ACTION_STEPS) >> FRAC_SHIFT;
  endfunction

  function automatic int unsigned row_start(logic [FRAC_W-1:0] inf, logic [FRAC_W-1:0] hosp);
    return (level_q(inf) * (QUANT_LEVELS + 1) + level_q(hosp)) * ROW_LEN;
  endfunction

  function automatic longint q_at(int unsigned addr);
    return q_shadow.exists(addr) ? q_shadow[addr] : 64'sd0;
  endfunction

  // Lowest action index holding the greatest value of the row.
  function automatic int unsigned greedy_pick(int unsigned base, output longint best);
    int unsigned pick;
    longint      b;
    pick = 0;
    b = q_at(base);
    for (int unsigned a = 1; a < ROW_LEN; a++) begin
      if (q_at(base + a) > b) begin
        b = q_at(base + a);
        pick = a;
      end
    end
    best = b;
    return pick;
  endfunction

  // Exact product with a Q0.16 fraction, floored toward minus infinity.
  function automatic longint scale_q16(prob_t frac, longint x);
    longint f;
    f = frac;
    return (f * x) >>> FRAC_SHIFT;
  endfunction

  function automatic longint clip_q(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (QVALUE_WIDTH - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Works out the result of one item and applies its effect on table and epsilon.
  function automatic agent_action_t predict_action(
    logic [1:0] op, logic [FRAC_W-1:0] inf_now, logic [FRAC_W-1:0] hosp_now,
    logic [FRAC_W-1:0] inf_next, logic [FRAC_W-1:0] hosp_next,
    logic [FRAC_W-1:0] taken, logic signed [REW_W-1:0] reward,
    prob_t draw, prob_t rint);
    agent_action_t r;
    int unsigned   base, nbase, a, e;
    longint        best, cur, target, nq;
    r = '{default: '0};
    case (op)
      OP_SELECT: begin
        if (draw < eps) begin
          r.intensity = FRAC_W'(rint);
          r.index = IDX_W'(action_q(FRAC_W'(rint)));
          r.explored = 1'b1;
        end else begin
          a = greedy_pick(row_start(inf_now, hosp_now), best);
          r.index = IDX_W'(a);
          r.intensity = FRAC_W'((a * ONE_Q16 + ACTION_STEPS - 1) / ACTION_STEPS);
          r.value = best[VAL_W-1:0];
        end
      end
      OP_UPDATE: begin
        base = row_start(inf_now, hosp_now);
        nbase = row_start(inf_next, hosp_next);
        a = action_q(taken);
        void'(greedy_pick(nbase, best));
        cur = q_at(base + a);
        target = longint'(reward) + scale_q16(discount, best);
        nq = clip_q(cur + scale_q16(alpha, target - cur));
        q_shadow[base + a] = nq;
        r.index = IDX_W'(a);
        r.value = nq[VAL_W-1:0];
      end
      OP_DECAY: begin
        e = (32'(eps) * 32'(eps_decay)) >> FRAC_SHIFT;
        if (e < eps_floor) e = eps_floor;
        eps = e[PROB_W-1:0];
        r.value = VAL_W'(eps);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    agent_action_t want;
    if (!rst_n) begin
      q_shadow.delete();
      awaited_actions.delete();
      alpha = LR_RESET;
      discount = GAMMA_RESET;
      eps_start = EPS_RESET;
      eps_decay = DECAY_RESET;
      eps_floor = FLOOR_RESET;
      eps = EPS_RESET;
      fail_count = 0;
    end else begin
      // The result leaving now belongs to an item taken at an earlier edge.
      if (out_valid) begin
        if (awaited_actions.size() == 0) begin
          report("result arrived with no item waiting for one");
        end else begin
          want = awaited_actions.pop_front();
          if (out_action_intensity !== want.intensity)
            report($sformatf("action_intensity %0d, expected %0d",
                             out_action_intensity, want.intensity));
          if (out_action_index !== want.index)
            report($sformatf("action_index %0d, expected %0d",
                             out_action_index, want.index));
          if (out_explored !== want.explored)
            report($sformatf("explored %0b, expected %0b", out_explored, want.explored));
          if (out_value_out !== want.value)
            report($sformatf("value_out %0d, expected %0d",
                             out_value_out, $signed(want.value)));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEARNING_RATE: alpha = cfg_wdata;
          CFG_DISCOUNT:      discount = cfg_wdata;
          CFG_EPS_START: begin
            eps_start = cfg_wdata;
            eps = cfg_wdata;
          end
          CFG_EPS_DECAY:     eps_decay = cfg_wdata;
          CFG_EPS_FLOOR:     eps_floor = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy)
        awaited_actions = {awaited_actions,
          predict_action(in_op, in_infected_now, in_hospitalized_now,
          in_infected_next, in_hospitalized_next, in_taken_intensity, in_reward,
          in_random_draw, in_random_intensity)};
    end
    pending <= awaited_actions.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the tabular Q-learning agent: drives items and registers, gives the verdict.
module tb;
  import qla_pkg::*;

  // The op code that the block leaves unused; it must still give one zero result.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Cycles without any accepted item, result or register write before the run
  // is declared hung. The table clear after reset writes all 112211 entries
  // with no sign of progress, so the limit is set well above that sweep.
  localparam int WATCHDOG_LIMIT = 500000;

  // Quiet cycles let pass after the last result, well above the longest latency.
  localparam int DRAIN_CYCLES = 40;

  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 300;

  typedef struct {
    logic [1:0]         op;
    frac_t              inf_now;
    frac_t              hosp_now;
    frac_t              inf_next;
    frac_t              hosp_next;
    frac_t              taken;
    logic signed [31:0] reward;
    prob_t              draw;
    prob_t              rint;
  } agent_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [1:0]             in_op;
  frac_t                  in_infected_now;
  frac_t                  in_hospitalized_now;
  frac_t                  in_infected_next;
  frac_t                  in_hospitalized_next;
  frac_t                  in_taken_intensity;
  logic signed [REW_W-1:0] in_reward;
  prob_t                  in_random_draw;
  prob_t                  in_random_intensity;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   out_valid;
  frac_t                  out_action_intensity;
  logic [IDX_W-1:0]       out_action_index;
  logic                   out_explored;
  logic signed [VAL_W-1:0] out_value_out;

  int fail_count;
  int pending;
  int idle_cycles = 0;

  // When set, items follow one another with no gap at all.
  bit back_to_back = 1'b0;

  always #2 clk = ~clk;

  tabular_q_learning_agent dut (.*);

  qla_scoreboard u_scoreboard (.*);

  // The watchdog restarts on any sign of progress. It also covers the wait for
  // the table clear, since busy holds off every item during that time.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic agent_item_t mk_item(logic [1:0] op, frac_t inf, frac_t hosp,
                                          frac_t infn, frac_t hospn, frac_t taken,
                                          logic signed [31:0] reward, prob_t draw,
                                          prob_t rint);
    agent_item_t it;
    it.op = op;
    it.inf_now = inf;
    it.hosp_now = hosp;
    it.inf_next = infn;
    it.hosp_next = hospn;
    it.taken = taken;
    it.reward = reward;
    it.draw = draw;
    it.rint = rint;
    return it;
  endfunction

  // Most fractions land in a handful of low levels or near one, so the same
  // table rows are read and written again and learning builds up on them.
  // The rest spread over the full range and above one, which the block clamps.
  function automatic frac_t rand_frac();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return frac_t'($urandom_range(0, 1999));
    if (pick < 75) return frac_t'($urandom_range(64880, ONE_Q16));
    if (pick < 90) return frac_t'($urandom_range(0, ONE_Q16));
    return frac_t'($urandom_range(ONE_Q16 + 1, (1 << FRAC_W) - 1));
  endfunction

  // Small rewards keep values in a readable range; full-range and extreme
  // rewards push the table into saturation now and then.
  function automatic logic signed [31:0] rand_reward();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $signed(32'($urandom_range(0, 1 << 21))) - (1 << 20);
    if (pick < 90) return $urandom;
    return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
  endfunction

  function automatic agent_item_t rand_item();
    agent_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      it.op = OP_SELECT;
    else if (pick < 85) it.op = OP_UPDATE;
    else if (pick < 95) it.op = OP_DECAY;
    else                it.op = OP_UNUSED;
    it.inf_now = rand_frac();
    it.hosp_now = rand_frac();
    it.inf_next = rand_frac();
    it.hosp_next = rand_frac();
    it.taken = ($urandom_range(0, 9) == 0) ? frac_t'($urandom_range(0, (1 << FRAC_W) - 1))
                                           : frac_t'($urandom_range(0, ONE_Q16));
    it.reward = rand_reward();
    it.draw = prob_t'($urandom_range(0, 65535));
    it.rint = prob_t'($urandom_range(0, 65535));
    return it;
  endfunction

  // Drives one item from a falling edge and holds it until the block takes it.
  // The random gap before it lands on any phase of the previous item's work.
  task automatic send_item(agent_item_t it);
    int gap;
    if ($urandom_range(0, 15) == 0) back_to_back = !back_to_back;
    gap = back_to_back ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op = it.op;
    in_infected_now = it.inf_now;
    in_hospitalized_now = it.hosp_now;
    in_infected_next = it.inf_next;
    in_hospitalized_next = it.hosp_next;
    in_taken_intensity = it.taken;
    in_reward = it.reward;
    in_random_draw = it.draw;
    in_random_intensity = it.rint;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_settings(prob_t lr, prob_t disc, prob_t eps0, prob_t dec, prob_t flr);
    write_reg(CFG_LEARNING_RATE, lr);
    write_reg(CFG_DISCOUNT, disc);
    write_reg(CFG_EPS_START, eps0);
    write_reg(CFG_EPS_DECAY, dec);
    write_reg(CFG_EPS_FLOOR, flr);
  endtask

  // Stops issuing items and waits until every predicted result has come back,
  // then lets the block settle before anything else is changed.
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_SELECT;
    in_infected_now = '0;
    in_hospitalized_now = '0;
    in_infected_next = '0;
    in_hospitalized_next = '0;
    in_taken_intensity = '0;
    in_reward = '0;
    in_random_draw = '0;
    in_random_intensity = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_LEARNING_RATE;
    cfg_wdata = '0;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // The block clears its table after reset and is busy until that is done.
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);

    // Directed items under the reset settings. An all-zero row must give the
    // lowest action. A draw equal to epsilon does not explore, one below does.
    send_item(mk_item(OP_SELECT, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0));
    send_item(mk_item(OP_SELECT, ONE_Q16, ONE_Q16, 0, 0, 0, 0, EPS_RESET, 0));
    send_item(mk_item(OP_SELECT, 0, 0, 0, 0, 0, 0, EPS_RESET - 1, 16'hFFFF));
    send_item(mk_item(OP_SELECT, 0, 0, 0, 0, 0, 0, 0, 0));
    // Largest reward on the top action, then fractions above one that clamp
    // to the last level and the last action, with the smallest reward.
    send_item(mk_item(OP_UPDATE, 0, 0, 0, 0, ONE_Q16, 32'sh7FFF_FFFF, 0, 0));
    send_item(mk_item(OP_UPDATE, 17'h1FFFF, 17'h1FFFF, 16'hFFFF, 1, 17'h1FFFF,
                      32'sh8000_0000, 0, 0));
    // A negative value on action 0 of the row at level 5, 5: greedy must move to action 1.
    send_item(mk_item(OP_UPDATE, 3277, 3277, 3277, 3277, 0, -32'sd65536, 0, 0));
    send_item(mk_item(OP_SELECT, 3277, 3277, 0, 0, 0, 0, 16'hFFFF, 0));
    // Row zero now favors the top action, whose intensity is exactly one.
    send_item(mk_item(OP_SELECT, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0));
    send_item(mk_item(OP_UNUSED, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
                      32'shFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_item(mk_item(OP_DECAY, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_DECAY, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // Full learning rate and discount make the new value jump to the target,
    // which overflows and must saturate. A zero decay drops epsilon to the
    // floor, here the largest value. Writes to indexes past the last register
    // must change nothing.
    load_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    for (int k = 1; k <= 3; k++) write_reg(CFG_EPS_FLOOR + CFG_IDX_W'(k), 16'h0000);
    send_item(mk_item(OP_SELECT, 0, 0, 0, 0, 0, 0, 0, 16'h1234));
    send_item(mk_item(OP_UPDATE, 0, 0, 0, 0, ONE_Q16, 32'sh7FFF_FFFF, 0, 0));
    send_item(mk_item(OP_UPDATE, 0, 0, 0, 0, ONE_Q16, 32'sh7FFF_FFFF, 0, 0));
    send_item(mk_item(OP_UPDATE, 0, 0, ONE_Q16, 0, 0, 32'sh8000_0000, 0, 0));
    send_item(mk_item(OP_UPDATE, 0, 0, ONE_Q16, 0, 0, 32'sh8000_0000, 0, 0));
    send_item(mk_item(OP_DECAY, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_SELECT, 0, 0, 0, 0, 0, 0, 16'hFFFE, 16'h8000));
    send_item(mk_item(OP_SELECT, 0, 0, 0, 0, 0, 0, 16'hFFFF, 16'h8000));

    // Random phases, each under its own settings: the reset values, all zero,
    // all at the top, and then random values. The random start epsilon stays
    // moderate so that both greedy and exploring selects occur.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: load_settings(LR_RESET, GAMMA_RESET, EPS_RESET, DECAY_RESET, FLOOR_RESET);
        1: load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        2: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: load_settings(prob_t'($urandom_range(0, 65535)),
                               prob_t'($urandom_range(0, 65535)),
                               prob_t'($urandom_range(0, 40000)),
                               prob_t'($urandom_range(0, 65535)),
                               prob_t'($urandom_range(0, 20000)));
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(rand_item());
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
